### hw/rtl/assert_macros.svh
// Assertion macros for the RTL of the Sobel gradient block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every rising clock edge outside reset.
`define SOBEL_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checks that a condition never holds at a rising clock edge outside reset.
`define SOBEL_NEVER(name, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

### hw/rtl/sobel_pkg.sv
// Types and constants shared by the Sobel gradient modules.
package sobel_pkg;

   localparam int PIXEL_W  = 8;
   localparam int GRAD_W   = 11;
   localparam int IWIDTH_W = 11;
   localparam int HEIGHT_W = 16;
   localparam int ROW_W    = HEIGHT_W + 1;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;

   localparam int IMAGE_WIDTH_RESET  = 640;
   localparam int IMAGE_HEIGHT_RESET = 480;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 8'd1;

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   // One window column, element 0 is the top row.
   typedef logic [2:0][PIXEL_W-1:0] column_type;

   // Which rows and outer columns of the 3x3 patch lie inside the image.
   typedef struct packed {
      logic top;
      logic bottom;
      logic left;
      logic right;
   } mask_type;

   // Control carried from the address stage to the window stage.
   typedef struct packed {
      logic     emit;
      logic     last;
      logic     clear;
      mask_type mask;
   } stage_ctl_type;

endpackage

### hw/rtl/sobel_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module sobel_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/sobel_kernel.sv
// Sobel 3x3 weighted sums over a masked patch of three columns.
module sobel_kernel (
   input  sobel_pkg::column_type              left_col,
   input  sobel_pkg::column_type              center_col,
   input  sobel_pkg::column_type              right_col,
   input  sobel_pkg::mask_type                mask,
   output logic signed [sobel_pkg::GRAD_W-1:0] grad_x,
   output logic signed [sobel_pkg::GRAD_W-1:0] grad_y
);

   localparam int SUM_W = sobel_pkg::PIXEL_W + 3;

   logic [sobel_pkg::PIXEL_W-1:0] lt, lm, lb, ct, cb, rt, rm, rb;
   logic [SUM_W-1:0] sum_left, sum_right, sum_top, sum_bottom;
   logic signed [SUM_W:0] diff_x, diff_y;

   always_comb begin
      // The middle row and the center column always lie inside the image.
      // The center pixel carries no weight in either direction.
      lt = (mask.left  && mask.top)    ? left_col[0]   : '0;
      lm =  mask.left                  ? left_col[1]   : '0;
      lb = (mask.left  && mask.bottom) ? left_col[2]   : '0;
      ct =  mask.top                   ? center_col[0] : '0;
      cb =  mask.bottom                ? center_col[2] : '0;
      rt = (mask.right && mask.top)    ? right_col[0]  : '0;
      rm =  mask.right                 ? right_col[1]  : '0;
      rb = (mask.right && mask.bottom) ? right_col[2]  : '0;

      sum_left   = SUM_W'(lt) + SUM_W'({lm, 1'b0}) + SUM_W'(lb);
      sum_right  = SUM_W'(rt) + SUM_W'({rm, 1'b0}) + SUM_W'(rb);
      sum_top    = SUM_W'(lt) + SUM_W'({ct, 1'b0}) + SUM_W'(rt);
      sum_bottom = SUM_W'(lb) + SUM_W'({cb, 1'b0}) + SUM_W'(rb);

      diff_x = $signed({1'b0, sum_right})  - $signed({1'b0, sum_left});
      diff_y = $signed({1'b0, sum_bottom}) - $signed({1'b0, sum_top});
      grad_x = diff_x[sobel_pkg::GRAD_W-1:0];
      grad_y = diff_y[sobel_pkg::GRAD_W-1:0];
   end

endmodule

### hw/rtl/sobel_gradient_3x3_core.sv
// Top level of the streaming Sobel 3x3 gradient block.
//
//   Channel  Direction  Handshake                 Payload
//   req_     in         req_tvalid / req_tready   tdata: pixel; tuser: command
//   rsp_     out        rsp_tvalid / rsp_tready   tdata: grad_x, grad_y; tlast
//   csr_     in         csr_valid / csr_ready     csr_index, csr_data
//
// One transaction is taken per cycle when req_tready is high; it is registered in
// the window stage and its result in the output register. The rate is set by the
// line-store RAM, which is read in the first stage and written back in the second
// with forwarding. Reset is synchronous and needs no clearing pass; the line
// stores are masked by row position instead. When a result waits and the window
// stage holds an item with a result, req_tready drops until rsp_tready returns.
`include "assert_macros.svh"

module sobel_gradient_3x3_core #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] pixel
   input  logic        req_tuser,   // [0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [10:0] grad_x, [21:11] grad_y, [23:22] zero
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [sobel_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sobel_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int ADDR_W      = $clog2(MAX_WIDTH);
   localparam int RESET_WIDTH = (sobel_pkg::IMAGE_WIDTH_RESET > MAX_WIDTH) ?
                                MAX_WIDTH : sobel_pkg::IMAGE_WIDTH_RESET;
   localparam logic [ADDR_W-1:0] RESET_WLAST = ADDR_W'(RESET_WIDTH - 1);
   localparam int PW = sobel_pkg::PIXEL_W;
   localparam int RW = sobel_pkg::ROW_W;
   localparam int HW = sobel_pkg::HEIGHT_W;
   localparam int GW = sobel_pkg::GRAD_W;

   // Configuration, kept in effective form.
   logic [ADDR_W-1:0] wlast_ff, wlast_in;
   logic [HW-1:0]     height_ff, height_in;

   // Raster position of the next transaction.
   logic [ADDR_W-1:0] col_ff, col_in;
   logic [RW-1:0]     row_ff, row_in;

   // Window stage.
   logic                     b_valid_ff, b_valid_in;
   logic [ADDR_W-1:0]        b_addr_ff, b_addr_in;
   logic [PW-1:0]            b_pix_ff, b_pix_in;
   sobel_pkg::stage_ctl_type b_ctl_ff, b_ctl_in;
   sobel_pkg::column_type    win_mid_ff, win_mid_in;
   sobel_pkg::column_type    win_right_ff, win_right_in;

   // Forwarding of a write-back to the same line-store entry.
   logic              fwd_ff, fwd_in;
   logic [2*PW-1:0]   fwd_data_ff, fwd_data_in;

   // Output register.
   logic          rsp_valid_ff, rsp_valid_in;
   logic [GW-1:0] rsp_gx_ff, rsp_gx_in;
   logic [GW-1:0] rsp_gy_ff, rsp_gy_in;
   logic          rsp_last_ff, rsp_last_in;

   logic csr_accept, restart, req_accept, is_drain, idle_drain, step;
   logic stall_b, b_advance, a_wrap, a_mid, a_last;
   logic [RW-1:0]  height_ext, height_p1;
   logic [PW-1:0]  a_pix;
   sobel_pkg::stage_ctl_type a_ctl;
   logic [31:0]    width_val;
   logic [2*PW-1:0] ram_rd_data, line_data, wr_data;
   sobel_pkg::column_type new_col;
   logic signed [GW-1:0] grad_x, grad_y;

   assign csr_ready  = 1'b1;
   assign csr_accept = csr_valid && csr_ready;
   assign restart    = csr_accept && (csr_index == sobel_pkg::REG_IMAGE_WIDTH ||
                                      csr_index == sobel_pkg::REG_IMAGE_HEIGHT);

   assign stall_b    = b_valid_ff && b_ctl_ff.emit && rsp_valid_ff && !rsp_tready;
   assign b_advance  = b_valid_ff && !stall_b;
   assign req_tready = !stall_b;
   assign req_accept = req_tvalid && req_tready;

   assign height_ext = {1'b0, height_ff};
   assign height_p1  = height_ext + RW'(1);

   // Configuration registers.
   always_comb begin
      wlast_in  = wlast_ff;
      height_in = height_ff;
      width_val = 32'(csr_data[sobel_pkg::IWIDTH_W-1:0]);
      if (csr_accept && csr_index == sobel_pkg::REG_IMAGE_WIDTH) begin
         if (width_val == 32'd0) begin
            wlast_in = '0;
         end else if (width_val > 32'(MAX_WIDTH)) begin
            wlast_in = ADDR_W'(MAX_WIDTH - 1);
         end else begin
            wlast_in = ADDR_W'(width_val - 32'd1);
         end
      end
      if (csr_accept && csr_index == sobel_pkg::REG_IMAGE_HEIGHT) begin
         height_in = (csr_data == '0) ? HW'(1) : csr_data[HW-1:0];
      end
   end

   // Address stage: position bookkeeping and line-store read.
   always_comb begin
      is_drain   = (req_tuser == sobel_pkg::CMD_DRAIN);
      idle_drain = is_drain && col_ff == '0 && row_ff == '0;
      step       = req_accept && !idle_drain;
      a_pix      = (!is_drain && row_ff < height_ext) ? req_tdata[PW-1:0] : '0;

      // A result for the last pixel of the row above comes out at column zero.
      a_wrap = (col_ff == '0) && (row_ff >= RW'(2));
      a_mid  = (col_ff != '0) && (row_ff != '0) && (row_ff <= height_ext);
      a_last = a_wrap && (row_ff == height_p1);

      a_ctl.emit  = a_wrap || a_mid;
      a_ctl.last  = a_last;
      a_ctl.clear = a_last;
      if (a_wrap) begin
         a_ctl.mask.top    = row_ff >= RW'(3);
         a_ctl.mask.bottom = row_ff <= height_ext;
         a_ctl.mask.left   = wlast_ff != '0;
         a_ctl.mask.right  = 1'b0;
      end else begin
         a_ctl.mask.top    = row_ff >= RW'(2);
         a_ctl.mask.bottom = 1'b1;
         a_ctl.mask.left   = col_ff >= ADDR_W'(2);
         a_ctl.mask.right  = 1'b1;
      end

      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (step) begin
         if (a_last) begin
            col_in = '0;
            row_in = '0;
         end else if (col_ff == wlast_ff) begin
            col_in = '0;
            row_in = row_ff + RW'(1);
         end else begin
            col_in = col_ff + ADDR_W'(1);
         end
      end

      b_valid_in = b_valid_ff;
      if (step) begin
         b_valid_in = 1'b1;
      end else if (b_advance) begin
         b_valid_in = 1'b0;
      end
      b_addr_in = step ? col_ff : b_addr_ff;
      b_pix_in  = step ? a_pix  : b_pix_ff;
      b_ctl_in  = step ? a_ctl  : b_ctl_ff;
   end

   // Window stage: the line-store entry holds {upper, middle}.
   always_comb begin
      line_data  = fwd_ff ? fwd_data_ff : ram_rd_data;
      wr_data    = {line_data[PW-1:0], b_pix_ff};
      new_col[0] = line_data[2*PW-1:PW];
      new_col[1] = line_data[PW-1:0];
      new_col[2] = b_pix_ff;

      // A read issued while the stage writes the same entry gets the new data.
      fwd_in      = fwd_ff;
      fwd_data_in = fwd_data_ff;
      if (step) begin
         fwd_in      = b_advance && (b_addr_ff == col_ff);
         fwd_data_in = wr_data;
      end else if (b_advance) begin
         fwd_in      = 1'b0;
      end

      win_mid_in   = win_mid_ff;
      win_right_in = win_right_ff;
      if (restart || (b_advance && b_ctl_ff.clear)) begin
         win_mid_in   = '0;
         win_right_in = '0;
      end else if (b_advance) begin
         win_mid_in   = win_right_ff;
         win_right_in = new_col;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_gx_in    = rsp_gx_ff;
      rsp_gy_in    = rsp_gy_ff;
      rsp_last_in  = rsp_last_ff;
      if (b_advance && b_ctl_ff.emit) begin
         rsp_valid_in = 1'b1;
         rsp_gx_in    = grad_x;
         rsp_gy_in    = grad_y;
         rsp_last_in  = b_ctl_ff.last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   sobel_ram #(
      .WIDTH (2 * PW),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (b_advance),
      .wr_addr (b_addr_ff),
      .wr_data (wr_data),
      .rd_en   (step),
      .rd_addr (col_ff),
      .rd_data (ram_rd_data)
   );

   // The window's two newest columns are the left and center of the patch.
   sobel_kernel u_kernel (
      .left_col   (win_mid_ff),
      .center_col (win_right_ff),
      .right_col  (new_col),
      .mask       (b_ctl_ff.mask),
      .grad_x     (grad_x),
      .grad_y     (grad_y)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         wlast_ff     <= RESET_WLAST;
         height_ff    <= HW'(sobel_pkg::IMAGE_HEIGHT_RESET);
         col_ff       <= '0;
         row_ff       <= '0;
         b_valid_ff   <= 1'b0;
         fwd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         win_mid_ff   <= '0;
         win_right_ff <= '0;
      end else begin
         wlast_ff     <= wlast_in;
         height_ff    <= height_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         b_valid_ff   <= b_valid_in;
         fwd_ff       <= fwd_in;
         rsp_valid_ff <= rsp_valid_in;
         win_mid_ff   <= win_mid_in;
         win_right_ff <= win_right_in;
      end
   end

   always_ff @(posedge clock) begin
      b_addr_ff   <= b_addr_in;
      b_pix_ff    <= b_pix_in;
      b_ctl_ff    <= b_ctl_in;
      fwd_data_ff <= fwd_data_in;
      rsp_gx_ff   <= rsp_gx_in;
      rsp_gy_ff   <= rsp_gy_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_gy_ff, rsp_gx_ff};
   assign rsp_tlast  = rsp_last_ff;

   `SOBEL_ASSERT(a_col_in_row, col_ff <= wlast_ff, "column position beyond the row width")
   `SOBEL_ASSERT(a_fwd_has_item, fwd_ff |-> b_valid_ff, "forwarded data without an item")
   `SOBEL_ASSERT(a_last_emits,
                 (b_valid_ff && b_ctl_ff.last) |-> b_ctl_ff.emit,
                 "frame end without a result")
   `SOBEL_ASSERT(a_frame_restart,
                 (step && a_last && !restart) |=> (col_ff == '0 && row_ff == '0),
                 "position not cleared at frame end")

endmodule
